### hdl/bta_pkg.sv
package bta_pkg;

	localparam int OpW = 2;
	localparam int StW = 3;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_BIG     = 3'd2,
		ST_NOFIT   = 3'd3,
		ST_IGNORED = 3'd4,
		ST_BADPTR  = 3'd5,
		ST_DOUBLE  = 3'd6,
		ST_CORRUPT = 3'd7
	} status_t;

	localparam logic [1:0] CFG_HEAP_WORDS = 2'd0;
	localparam logic [1:0] CFG_CHECK      = 2'd1;
	localparam logic [1:0] CFG_LIMIT      = 2'd2;

	typedef enum logic [5:0] {
		S_IDLE,
		S_DISPATCH,
		// init
		S_I0, S_I1, S_I2, S_I3, S_I4,
		// generic sequenced read: issue then capture
		S_RD, S_RDW,
		// alloc walk
		S_A_HDR, S_A_EVAL, S_A_NEXT, S_A_CHK,
		// unlink (pick for alloc or neighbor for free)
		S_U_PV, S_U_NX, S_U_CHKP, S_U_CHKN, S_U_W1, S_U_W2,
		// alloc finish
		S_A_T0, S_A_T1, S_A_SPLIT,
		// mark_free sequence
		S_M0, S_M1, S_M2, S_M3, S_M4,
		// free
		S_F_HDR, S_F_CHK, S_F_LSZ, S_F_LHDR, S_F_LCHK, S_F_RHDR, S_F_RCHK,
		S_F_MERGE_L, S_F_MERGE_R, S_F_DONE,
		// metadata check
		S_C_HDR, S_C_FTR, S_C_CMP,
		S_DONE
	} state_t;

endpackage

### hdl/boundary_tag_heap_allocator.sv
// alloc time grows with each free-list node visited, and further with metadata checks, also
// during unlink; free takes longer when it merges on both sides or runs metadata checks
// throughput: one operation at a time; the next beat is accepted once the result is taken
// reset: control, free head and heap length clear; heap ram content is undefined until init
module boundary_tag_heap_allocator
	import bta_pkg::*;
#(
	parameter int HEAP_WORDS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // op[1:0], request_bytes[33:2], free_offset[45:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // payload_offset[11:0], block_words[24:12], status[27:25]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int AW = $clog2(HEAP_WORDS);

	state_t state_q, state_n, ret_q, cret_q;

	logic [12:0] heap_words_q;
	logic        check_q;
	logic [7:0]  limit_q;

	logic [15:0] len_q;
	logic [15:0] head_q;

	op_t         op_q;
	logic [31:0] bytes_q;
	logic [11:0] foff_q;

	logic [15:0] need_q, best_q, pick_q, p_q, sz_q, blk_q, lft_q, rgt_q;
	logic [15:0] ua_q, pv_q, nx_q, mf_a_q, mf_n_q, ca_q, chdr_q, rd_q;
	logic [8:0]  cnt_q;
	logic [16:0] steps_q;
	logic [1:0]  uphase_q;
	logic        ufrom_alloc_q, bad_q;

	logic [11:0] out_off_q;
	logic [12:0] out_words_q;
	status_t     out_st_q;
	logic        out_v_q;

	// ram port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [15:0]       ram_wdata, ram_rdata;
	logic [15:0]       raddr_q;

	bta_ram #(.Width(16), .Depth(HEAP_WORDS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign s_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, out_st_q, out_words_q, out_off_q};
	assign ram_raddr = raddr_q[AW-1:0];

	// single sequential controller; each memory read: set raddr_q, wait in S_RD, capture in S_RDW
	logic [16:0] need_w;
	logic [15:0] ilen;
	always_comb begin
		need_w = {15'd0, 2'd0} + 17'(bytes_q[31:2]) + 17'(bytes_q[1:0] != 2'd0) + 17'd4;
		if (bytes_q[31:18] != 14'd0) need_w = 17'h1FFFE;
		if (need_w[0]) need_w = need_w + 17'd1;
		ilen = (heap_words_q < 13'd10) ? 16'd10 :
		       (32'(heap_words_q) > HEAP_WORDS) ? 16'(HEAP_WORDS) : {3'd0, heap_words_q};
		ilen[0] = 1'b0;
	end

	always_comb begin
		state_n = state_q;
		if (state_q == S_IDLE && s_tready && s_tvalid) state_n = S_DISPATCH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			cret_q <= S_IDLE;
			heap_words_q <= 13'd4096;
			check_q <= 1'b0;
			limit_q <= 8'd20;
			len_q <= '0;
			head_q <= '0;
			out_v_q <= 1'b0;
			ram_we <= 1'b0;
		end else begin
			ram_we <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_HEAP_WORDS: heap_words_q <= cfg_data;
					CFG_CHECK:      check_q <= cfg_data[0];
					CFG_LIMIT:      limit_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tready && s_tvalid) begin
						op_q <= op_t'(s_tdata[1:0]);
						bytes_q <= s_tdata[33:2];
						foff_q <= s_tdata[45:34];
						bad_q <= 1'b0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					out_off_q <= '0;
					out_words_q <= '0;
					case (op_q)
						OP_INIT: begin
							len_q <= ilen;
							head_q <= '0;
							state_q <= S_I0;
						end
						OP_ALLOC: begin
							if (bytes_q == 32'd0) begin
								out_st_q <= ST_ZERO; state_q <= S_DONE;
							end else if (len_q == 16'd0) begin
								out_st_q <= ST_NOFIT; state_q <= S_DONE;
							end else if (need_w > 17'(len_q - 16'd4)) begin
								out_st_q <= ST_BIG; state_q <= S_DONE;
							end else begin
								need_q <= need_w[15:0];
								best_q <= 16'hFFFF;
								pick_q <= '0;
								p_q <= head_q;
								cnt_q <= (limit_q == 8'd0) ? 9'd256 : {1'b0, limit_q};
								steps_q <= '0;
								state_q <= S_A_HDR;
							end
						end
						OP_FREE: begin
							if (foff_q == 12'd0) begin
								out_st_q <= ST_IGNORED; state_q <= S_DONE;
							end else if ({4'd0, foff_q} >= len_q || foff_q < 12'd3) begin
								out_st_q <= ST_BADPTR; state_q <= S_DONE;
							end else begin
								blk_q <= {4'd0, foff_q} - 16'd3;
								ca_q <= {4'd0, foff_q} - 16'd3;
								cret_q <= S_F_CHK;
								state_q <= S_C_HDR;
							end
						end
						default: begin
							out_st_q <= ST_IGNORED; state_q <= S_DONE;
						end
					endcase
				end
				// ---- init ----
				S_I0: begin
					ram_we <= 1'b1; ram_waddr <= '0; ram_wdata <= 16'd3; state_q <= S_I1;
				end
				S_I1: begin
					ram_we <= 1'b1; ram_waddr <= AW'(1); ram_wdata <= 16'd3; state_q <= S_I2;
				end
				S_I2: begin
					ram_we <= 1'b1; ram_waddr <= AW'(len_q - 16'd2); ram_wdata <= 16'd3;
					state_q <= S_I3;
				end
				S_I3: begin
					ram_we <= 1'b1; ram_waddr <= AW'(len_q - 16'd1); ram_wdata <= 16'd3;
					out_words_q <= 13'(len_q - 16'd4);
					mf_a_q <= 16'd2; mf_n_q <= len_q - 16'd4;
					ret_q <= S_I4;
					state_q <= S_M0;
				end
				S_I4: begin
					out_st_q <= ST_OK; state_q <= S_DONE;
				end
				// ---- read helper ----
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					rd_q <= ram_rdata; state_q <= ret_q;
				end
				// ---- alloc walk ----
				S_A_HDR: begin
					if (bad_q) begin
						out_st_q <= ST_CORRUPT; state_q <= S_DONE;
					end else if (p_q == 16'd0) begin
						if (pick_q == 16'd0) begin
							out_st_q <= ST_NOFIT; state_q <= S_DONE;
						end else begin
							ua_q <= pick_q; ufrom_alloc_q <= 1'b1; state_q <= S_U_PV;
							raddr_q <= pick_q + 16'd2;
						end
					end else if (steps_q == 17'(HEAP_WORDS)) begin
						out_st_q <= ST_CORRUPT; state_q <= S_DONE;
					end else begin
						steps_q <= steps_q + 17'd1;
						raddr_q <= p_q; ret_q <= S_A_EVAL; state_q <= S_RD;
					end
				end
				S_A_EVAL: begin
					if (rd_q[0]) begin
						out_st_q <= ST_CORRUPT; state_q <= S_DONE;
					end else begin
						state_q <= S_A_NEXT;
						raddr_q <= p_q + 16'd1;
						ret_q <= S_A_CHK;
						if ({rd_q[15:1], 1'b0} >= need_q) begin
							if ({rd_q[15:1], 1'b0} < best_q) begin
								best_q <= {rd_q[15:1], 1'b0}; pick_q <= p_q;
							end
							cnt_q <= cnt_q - 9'd1;
							if (cnt_q == 9'd1 || {rd_q[15:1], 1'b0} == need_q) p_q <= '0;
							if (cnt_q == 9'd1 || {rd_q[15:1], 1'b0} == need_q)
								state_q <= S_A_HDR;
						end
					end
				end
				S_A_NEXT: state_q <= S_RD;
				S_A_CHK: begin
					p_q <= rd_q; ca_q <= rd_q; cret_q <= S_A_HDR; state_q <= S_C_HDR;
				end
				// ---- unlink ua_q; raddr preset to ua+2 ----
				S_U_PV: begin
					ret_q <= S_U_CHKP; state_q <= S_RD;
				end
				S_U_CHKP: begin
					pv_q <= rd_q; ca_q <= rd_q; cret_q <= S_U_NX; state_q <= S_C_HDR;
				end
				S_U_NX: begin
					if (bad_q) begin
						out_st_q <= ST_CORRUPT; state_q <= S_DONE;
					end else begin
						raddr_q <= ua_q + 16'd1; ret_q <= S_U_CHKN; state_q <= S_RD;
					end
				end
				S_U_CHKN: begin
					nx_q <= rd_q; ca_q <= rd_q; cret_q <= S_U_W1; state_q <= S_C_HDR;
				end
				S_U_W1: begin
					if (bad_q) begin
						out_st_q <= ST_CORRUPT; state_q <= S_DONE;
					end else begin
						if (pv_q == 16'd0) head_q <= nx_q;
						else begin
							ram_we <= 1'b1; ram_waddr <= AW'(pv_q + 16'd1); ram_wdata <= nx_q;
						end
						state_q <= S_U_W2;
					end
				end
				S_U_W2: begin
					if (nx_q != 16'd0) begin
						ram_we <= 1'b1; ram_waddr <= AW'(nx_q + 16'd2); ram_wdata <= pv_q;
					end
					if (ufrom_alloc_q) state_q <= S_A_T0;
					else begin
						// size is read again once the link writes have landed
						raddr_q <= ua_q;
						ret_q <= (uphase_q == 2'd0) ? S_F_MERGE_L : S_F_MERGE_R;
						state_q <= S_A_NEXT;
					end
				end
				// ---- alloc finish ----
				S_A_T0: begin
					if (best_q - need_q >= 16'd4) sz_q <= need_q;
					else sz_q <= best_q;
					state_q <= S_A_T1;
				end
				S_A_T1: begin
					// header write, then footer at the end of the taken block (pick + sz - 1)
					ram_we <= 1'b1; ram_waddr <= AW'(pick_q); ram_wdata <= sz_q + 16'd1;
					state_q <= S_A_SPLIT;
				end
				S_A_SPLIT: begin
					ram_we <= 1'b1; ram_waddr <= AW'(pick_q + sz_q - 16'd1);
					ram_wdata <= sz_q + 16'd1;
					out_off_q <= 12'(pick_q + 16'd3);
					out_words_q <= 13'(sz_q);
					if (best_q - need_q >= 16'd4) begin
						mf_a_q <= pick_q + need_q; mf_n_q <= best_q - need_q;
						ret_q <= S_I4; state_q <= S_M0;
					end else state_q <= S_I4;
				end
				// ---- mark_free mf_a_q, mf_n_q (n even, footer at a+n-1) ----
				S_M0: begin
					ram_we <= 1'b1; ram_waddr <= AW'(mf_a_q); ram_wdata <= mf_n_q;
					state_q <= S_M1;
				end
				S_M1: begin
					ram_we <= 1'b1; ram_waddr <= AW'(mf_a_q + {mf_n_q[15:1], 1'b0} - 16'd1);
					ram_wdata <= mf_n_q; state_q <= S_M2;
				end
				S_M2: begin
					ram_we <= 1'b1; ram_waddr <= AW'(mf_a_q + 16'd1); ram_wdata <= head_q;
					state_q <= S_M3;
				end
				S_M3: begin
					ram_we <= 1'b1; ram_waddr <= AW'(mf_a_q + 16'd2); ram_wdata <= '0;
					state_q <= S_M4;
				end
				S_M4: begin
					if (head_q != 16'd0) begin
						ram_we <= 1'b1; ram_waddr <= AW'(head_q + 16'd2); ram_wdata <= mf_a_q;
					end
					head_q <= mf_a_q;
					state_q <= ret_q;
				end
				// ---- free ----
				S_F_CHK: begin
					if (bad_q) begin
						out_st_q <= ST_CORRUPT; state_q <= S_DONE;
					end else begin
						raddr_q <= blk_q; ret_q <= S_F_HDR; state_q <= S_RD;
					end
				end
				S_F_HDR: begin
					if (!rd_q[0]) begin
						out_st_q <= ST_DOUBLE; state_q <= S_DONE;
					end else begin
						sz_q <= {rd_q[15:1], 1'b0};
						raddr_q <= blk_q - 16'd1; ret_q <= S_F_LSZ; state_q <= S_RD;
					end
				end
				S_F_LSZ: begin
					lft_q <= blk_q - {rd_q[15:1], 1'b0};
					ca_q <= blk_q - {rd_q[15:1], 1'b0};
					rgt_q <= blk_q + sz_q;
					cret_q <= S_F_LCHK; state_q <= S_C_HDR;
				end
				S_F_LCHK: begin
					ca_q <= rgt_q; cret_q <= S_F_RCHK; state_q <= S_C_HDR;
				end
				S_F_RCHK: begin
					if (bad_q) begin
						out_st_q <= ST_CORRUPT; state_q <= S_DONE;
					end else begin
						raddr_q <= lft_q; ret_q <= S_F_LHDR; state_q <= S_RD;
					end
				end
				S_F_LHDR: begin
					if (!rd_q[0]) begin
						ua_q <= lft_q; ufrom_alloc_q <= 1'b0; uphase_q <= 2'd0;
						best_q <= {rd_q[15:1], 1'b0};
						raddr_q <= lft_q + 16'd2; state_q <= S_U_PV;
					end else begin
						raddr_q <= rgt_q; ret_q <= S_F_RHDR; state_q <= S_RD;
					end
				end
				S_F_MERGE_L: begin
					blk_q <= lft_q; sz_q <= sz_q + {rd_q[15:1], 1'b0};
					raddr_q <= rgt_q; ret_q <= S_F_RHDR; state_q <= S_RD;
				end
				S_F_RHDR: begin
					if (!rd_q[0]) begin
						ua_q <= rgt_q; ufrom_alloc_q <= 1'b0; uphase_q <= 2'd1;
						best_q <= {rd_q[15:1], 1'b0};
						raddr_q <= rgt_q + 16'd2; state_q <= S_U_PV;
					end else state_q <= S_F_DONE;
				end
				S_F_MERGE_R: begin
					sz_q <= sz_q + {rd_q[15:1], 1'b0}; state_q <= S_F_DONE;
				end
				S_F_DONE: begin
					out_words_q <= 13'(sz_q);
					mf_a_q <= blk_q; mf_n_q <= sz_q; ret_q <= S_I4; state_q <= S_M0;
				end
				// ---- metadata check of ca_q, returns to cret_q ----
				S_C_HDR: begin
					if (!check_q || ca_q == 16'd0) state_q <= cret_q;
					else if (ca_q >= len_q) begin
						bad_q <= 1'b1; state_q <= cret_q;
					end else begin
						raddr_q <= ca_q; ret_q <= S_C_FTR; state_q <= S_RD;
					end
				end
				S_C_FTR: begin
					chdr_q <= rd_q;
					if (ca_q + {rd_q[15:1], 1'b0} - 16'd1 >= len_q) begin
						bad_q <= 1'b1; state_q <= cret_q;
					end else begin
						raddr_q <= ca_q + {rd_q[15:1], 1'b0} - 16'd1;
						ret_q <= S_C_CMP; state_q <= S_RD;
					end
				end
				S_C_CMP: begin
					if (rd_q != chdr_q) bad_q <= 1'b1;
					state_q <= cret_q;
				end
				S_DONE: begin
					if (out_st_q != ST_OK) begin
						out_off_q <= '0; out_words_q <= '0;
					end
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic unused_ok;
	assign unused_ok = (state_n == state_q) | (rgt_q == 16'd0);

endmodule

### hdl/bta_ram.sv
module bta_ram #(
	parameter int Width = 16,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/bta_checker.sv
module bta_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted while busy");

	a_nores: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("ready with result pending");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[27:25] != 3'd0 |-> m_tdata[24:0] == 25'd0)
		else $error("failed result carries data");

endmodule

bind boundary_tag_heap_allocator bta_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### dv/heap_tracker.sv
`timescale 1ns / 1ps

module heap_tracker
	import bta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // op[1:0], request_bytes[33:2], free_offset[45:34]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // payload_offset[11:0], block_words[24:12], status[27:25]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output int          fails,
	output int          pend
);

	localparam int Words = 4096;

	typedef struct packed {
		logic [11:0] off;
		logic [12:0] words;
		status_t     st;
	} grant_t;

	logic [15:0] mem [Words];
	bit          wrt [Words];
	logic [31:0] head, clen, hw, chkm, lim;
	bit          badm, undef;
	grant_t      grants_q[$];

	function automatic logic [31:0] rd(logic [31:0] a);
		if (!wrt[a[11:0]])
			undef = 1;
		return {16'd0, mem[a[11:0]]};
	endfunction

	function automatic void wr(logic [31:0] a, logic [31:0] v);
		mem[a[11:0]] = v[15:0];
		wrt[a[11:0]] = 1;
	endfunction

	function automatic logic [31:0] bsz(logic [31:0] a);
		return rd(a) & 32'hFFFE;
	endfunction

	function automatic logic [31:0] chkd(logic [31:0] a);
		logic [31:0] f;
		if (chkm == 0 || a == 0)
			return a;
		if (a >= clen) begin
			badm = 1;
			return a;
		end
		f = a + bsz(a) - 1;
		if (f >= clen || rd(a) != rd(f))
			badm = 1;
		return a;
	endfunction

	function automatic void unlink(logic [31:0] a);
		logic [31:0] pv, nx;
		pv = chkd(rd(a + 2));
		nx = chkd(rd(a + 1));
		if (badm)
			return;
		if (pv == 0)
			head = nx;
		else
			wr(pv + 1, nx);
		if (nx != 0)
			wr(nx + 2, pv);
	endfunction

	function automatic void mark_free(logic [31:0] a, logic [31:0] n);
		wr(a, n);
		wr(a + bsz(a) - 1, n);
		wr(a + 1, head);
		wr(a + 2, 0);
		if (head != 0)
			wr(head + 2, a);
		head = a & 32'hFFFF;
	endfunction

	function automatic void mark_taken(logic [31:0] a, logic [31:0] n);
		wr(a, n + 1);
		wr(a + bsz(a) - 1, n + 1);
	endfunction

	function automatic status_t alloc_blk(logic [31:0] bytes, output logic [31:0] off,
			output logic [31:0] words);
		logic [63:0] need;
		logic [31:0] ent, best, pick, p, cnt, steps, sz, extra;
		off = 0;
		words = 0;
		if (bytes == 0)
			return ST_ZERO;
		if (clen == 0)
			return ST_NOFIT;
		need = {32'd0, bytes >> 2} + ((bytes[1:0] != 0) ? 1 : 0) + 4;
		if (need[0])
			need++;
		if (need > {32'd0, clen - 4})
			return ST_BIG;
		ent = need[31:0];
		best = 32'hFFFF_FFFF;
		pick = 0;
		steps = 0;
		cnt = (lim == 0) ? 256 : lim;
		p = head;
		while (p != 0) begin
			steps++;
			if (steps > Words)
				return ST_CORRUPT;
			if (rd(p) & 1)
				return ST_CORRUPT;
			sz = bsz(p);
			if (sz >= ent) begin
				if (sz < best) begin
					best = sz;
					pick = p;
				end
				cnt--;
				if (cnt == 0 || sz == ent)
					break;
			end
			p = chkd(rd(p + 1));
			if (badm)
				return ST_CORRUPT;
		end
		if (pick == 0)
			return ST_NOFIT;
		unlink(pick);
		if (badm)
			return ST_CORRUPT;
		extra = best - ent;
		if (extra >= 4) begin
			mark_taken(pick, ent);
			mark_free(pick + ent, extra);
			words = ent;
		end else begin
			mark_taken(pick, best);
			words = best;
		end
		off = pick + 3;
		return ST_OK;
	endfunction

	function automatic status_t free_blk(logic [31:0] offset, output logic [31:0] words);
		logic [31:0] blk, sz, lft, rgt;
		words = 0;
		if (offset == 0)
			return ST_IGNORED;
		if (offset >= clen || offset < 3)
			return ST_BADPTR;
		blk = offset - 3;
		void'(chkd(blk));
		if (badm)
			return ST_CORRUPT;
		if ((rd(blk) & 1) == 0)
			return ST_DOUBLE;
		sz = bsz(blk);
		lft = chkd((blk - 1) - bsz(blk - 1) + 1);
		rgt = chkd(blk + bsz(blk));
		if (badm)
			return ST_CORRUPT;
		if ((rd(lft) & 1) == 0) begin
			unlink(lft);
			if (badm)
				return ST_CORRUPT;
			blk = lft;
			sz += bsz(lft);
		end
		if ((rd(rgt) & 1) == 0) begin
			unlink(rgt);
			if (badm)
				return ST_CORRUPT;
			sz += bsz(rgt);
		end
		mark_free(blk, sz);
		words = sz;
		return ST_OK;
	endfunction

	function automatic grant_t apply_op(logic [1:0] op, logic [31:0] bytes, logic [11:0] foff);
		grant_t g;
		logic [31:0] off, words, n;
		status_t st;
		off = 0;
		words = 0;
		badm = 0;
		case (op)
			OP_ALLOC: st = alloc_blk(bytes, off, words);
			OP_FREE:  st = free_blk({20'd0, foff}, words);
			OP_INIT: begin
				n = hw;
				if (n < 10)
					n = 10;
				if (n > Words)
					n = Words;
				n[0] = 0;
				clen = n;
				head = 0;
				mark_taken(0, 2);
				mark_free(2, n - 4);
				mark_taken(n - 2, 2);
				words = n - 4;
				st = ST_OK;
			end
			default: st = ST_IGNORED;
		endcase
		if (st != ST_OK) begin
			off = 0;
			words = 0;
		end
		g.off = off[11:0];
		g.words = words[12:0];
		g.st = st;
		return g;
	endfunction

	// dry run on the current state: tells whether the op reads only defined words
	function automatic bit probe(logic [1:0] op, logic [31:0] bytes, logic [11:0] foff,
			output grant_t g);
		logic [15:0] mem_s [Words];
		bit          wrt_s [Words];
		logic [31:0] head_s, clen_s;
		mem_s = mem;
		wrt_s = wrt;
		head_s = head;
		clen_s = clen;
		undef = 0;
		g = apply_op(op, bytes, foff);
		mem = mem_s;
		wrt = wrt_s;
		head = head_s;
		clen = clen_s;
		return !undef;
	endfunction

	assign pend = grants_q.size();

	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		if (!arst_n) begin
			for (int i = 0; i < Words; i++) begin
				mem[i] = 0;
				wrt[i] = 0;
			end
			head = 0;
			clen = 0;
			hw = 4096;
			chkm = 0;
			lim = 20;
			fails = 0;
			grants_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (grants_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result beat %h", m_tdata);
				end else begin
					g = grants_q.pop_front();
					if (m_tdata[11:0] !== g.off || m_tdata[24:12] !== g.words ||
							m_tdata[27:25] !== g.st) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: exp off %0d words %0d st %0d, got off %0d words %0d st %0d",
								g.off, g.words, g.st,
								m_tdata[11:0], m_tdata[24:12], m_tdata[27:25]);
					end
				end
			end
			if (s_tvalid && s_tready)
				grants_q.push_back(apply_op(s_tdata[1:0], s_tdata[33:2], s_tdata[45:34]));
			if (cfg_we) begin
				case (cfg_index)
					CFG_HEAP_WORDS: hw = {19'd0, cfg_data};
					CFG_CHECK:      chkm = {31'd0, cfg_data[0]};
					CFG_LIMIT:      lim = {24'd0, cfg_data[7:0]};
					default: ;
				endcase
			end
		end
	end

endmodule

### dv/tb_boundary_tag_heap_allocator.sv
`timescale 1ns / 1ps

module tb_boundary_tag_heap_allocator;
	import bta_pkg::*;

	typedef struct packed {
		logic [11:0] off;
		logic [12:0] words;
		status_t     st;
	} grant_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = 0;   // op[1:0], request_bytes[33:2], free_offset[45:34]
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;       // payload_offset[11:0], block_words[24:12], status[27:25]
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = 0;
	logic [12:0] cfg_data = 0;
	int          fails, pend;
	int          cycles = 0;
	int          rx_wait = 0;
	bit          tx_steady = 0, rx_steady = 0;
	logic [11:0] live_q[$], dead_q[$];

	boundary_tag_heap_allocator uut (.*);

	heap_tracker chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("** boundary_tag_heap_allocator: FAILED **");
			$finish;
		end
		if (m_tvalid && m_tready)
			rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
	end

	always @(negedge clk) begin
		if (rx_wait > 0) begin
			m_tready <= 0;
			rx_wait--;
		end else
			m_tready <= 1;
	end

	// entered and left at a falling edge
	task automatic send_op(logic [1:0] op, logic [31:0] bytes, logic [11:0] foff);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		begin
			heap_tracker_grant(op, bytes, foff);
		end
	endtask

	task automatic heap_tracker_grant(logic [1:0] op, logic [31:0] bytes, logic [11:0] foff);
		grant_t g;
		if (!chk.probe(op, bytes, foff, g)) begin
			op = OP_FREE;
			foff = 0;
			void'(chk.probe(op, bytes, foff, g));
		end
		if (g.st == ST_OK) begin
			if (op == OP_ALLOC)
				live_q.push_back(g.off);
			else if (op == OP_FREE)
				dead_q.push_back(foff);
			else if (op == OP_INIT) begin
				live_q.delete();
				dead_q.delete();
			end
		end
		s_tvalid <= 1;
		s_tdata <= {2'd0, foff, bytes, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 0;
		@(negedge clk);
		while (pend != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [12:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic free_live;
		int k;
		logic [11:0] o;
		k = $urandom_range(0, live_q.size() - 1);
		o = live_q[k];
		live_q.delete(k);
		send_op(OP_FREE, 0, o);
	endtask

	task automatic random_op;
		int r;
		logic [31:0] b;
		r = $urandom_range(0, 99);
		if (r < 50 || (r < 85 && live_q.size() == 0)) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				b = 0;
			else if (r == 1)
				b = $urandom;
			else if (r < 5)
				b = $urandom_range(1, 600);
			else
				b = $urandom_range(1, 48);
			send_op(OP_ALLOC, b, 12'($urandom));
		end else if (r < 85)
			free_live();
		else if (r < 90 && dead_q.size() > 0)
			send_op(OP_FREE, $urandom, dead_q[$urandom_range(0, dead_q.size() - 1)]);
		else if (r < 97)
			send_op(OP_FREE, $urandom, 12'($urandom_range(0, 4095)));
		else if (r < 99)
			send_op(OP_NONE, $urandom, 12'($urandom));
		else
			send_op(OP_INIT, $urandom, 12'($urandom));
	endtask

	task automatic run_phase(logic [12:0] hwv, bit cm, logic [7:0] lm, int n);
		drain();
		set_reg(CFG_HEAP_WORDS, hwv);
		set_reg(CFG_CHECK, {12'd0, cm});
		set_reg(CFG_LIMIT, {5'd0, lm});
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		send_op(OP_INIT, 0, 0);
		for (int i = 0; i < n; i++) begin
			random_op();
			if (i == n / 2 && hwv == 13'd300)
				drain();
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: before init, init, extremes of request and pointer
		send_op(OP_ALLOC, 8, 0);
		send_op(OP_FREE, 0, 12'd5);
		send_op(OP_NONE, 32'hFFFF_FFFF, 12'hFFF);
		send_op(OP_INIT, 0, 0);
		send_op(OP_ALLOC, 0, 0);
		send_op(OP_ALLOC, 32'hFFFF_FFFF, 0);
		send_op(OP_ALLOC, 1, 0);
		send_op(OP_ALLOC, 4, 0);
		send_op(OP_ALLOC, 5, 0);
		send_op(OP_ALLOC, 16360, 0);
		send_op(OP_ALLOC, 100, 0);
		send_op(OP_FREE, 0, 0);
		send_op(OP_FREE, 0, 12'd1);
		send_op(OP_FREE, 0, 12'd2);
		send_op(OP_FREE, 0, 12'hFFF);
		while (live_q.size() > 0)
			free_live();
		if (dead_q.size() > 0)
			send_op(OP_FREE, 0, dead_q[0]);
		run_phase(13'd10, 1, 8'd1, 40);
		run_phase(13'h1FFF, 1, 8'd255, 50);
		run_phase(13'd0, 0, 8'd0, 40);
		run_phase(13'd300, 0, 8'd2, 70);
		run_phase(13'd11, 0, 8'd20, 30);
		for (int i = 0; i < 7; i++)
			run_phase(13'($urandom_range(20, 700)), 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), 65);
		drain();
		repeat (20) @(negedge clk);
		if (fails == 0 && pend == 0)
			$display("** boundary_tag_heap_allocator: PASSED **");
		else
			$display("** boundary_tag_heap_allocator: FAILED **");
		$finish;
	end

endmodule
